// File: rtl/mtps_pkg.sv
// Shared types and constants for the supersampled triangle pixel shader.
// Used by mtps_depth_unit and msaa_triangle_pixel_shader_core; no dependencies.
package mtps_pkg;

    localparam int SCREEN_WIDTH      = 256;
    localparam int SCREEN_HEIGHT     = 256;
    localparam int SAMPLES_PER_PIXEL = 4;

    localparam logic [23:0] FAR_DEPTH = 24'hFF_FFFF;

    // One stored sample: colour (red low) above depth.
    localparam int SAMPLE_W = 48;
    localparam int WORD_W   = SAMPLE_W * SAMPLES_PER_PIXEL;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_SHADE = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [1:0]         vertex_slot;
        logic signed [15:0] vertex_x;
        logic signed [15:0] vertex_y;
        logic [23:0]        vertex_depth;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         pixel_x;
        logic [7:0]         pixel_y;
    } in_item_t;

    typedef struct packed {
        logic        written;
        logic [15:0] frame_address;
        logic [7:0]  out_red;
        logic [7:0]  out_green;
        logic [7:0]  out_blue;
    } out_item_t;

    // Current triangle geometry handed to the depth unit.
    typedef struct packed {
        logic [2:0][15:0] vx;
        logic [2:0][15:0] vy;
        logic [2:0][23:0] vz;
    } geom_t;

    typedef struct packed {
        logic        done;
        logic        ok;
        logic [23:0] z;
    } depth_res_t;

    typedef enum logic [2:0] {
        DU_IDLE,
        DU_EDGE,
        DU_CHECK,
        DU_WEIGHT,
        DU_DIVIDE,
        DU_DONE
    } du_state_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DISPATCH,
        ST_READ,
        ST_LATCH,
        ST_SAMPLE,
        ST_WAIT,
        ST_WRITE,
        ST_FINISH
    } core_state_t;

endpackage

// File: rtl/msaa_triangle_pixel_shader_core.sv
// Top level of the 2x2 supersampled triangle pixel shader with sample store.
// Depends on mtps_pkg and mtps_depth_unit.
//
//   channel   signals                            direction
//   item      item_valid, item_ready, item       in
//   result    result_valid, result_ready, result out
//
// Load, off-screen and unused-opcode items go straight from dispatch to finish
// and clear items write the far-depth word first. A shade item runs its four
// samples through the depth unit in turn: a covered sample of a non-degenerate
// triangle takes its edge and weight products on the shared multiplier, then a
// 24-step divide, and a rejected one stops after its edge products.
// After reset the store is swept to far depth and black, all SCREEN_WIDTH*SCREEN_HEIGHT
// words (65536 by default), before the first item is taken. A stalled result holds
// the block before it finishes the next item.
module msaa_triangle_pixel_shader_core #(
    parameter int SCREEN_WIDTH  = mtps_pkg::SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = mtps_pkg::SCREEN_HEIGHT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  mtps_pkg::in_item_t    item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output mtps_pkg::out_item_t   result
);

    localparam int DEPTH  = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int WORD_W = mtps_pkg::WORD_W;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    mtps_pkg::core_state_t state_reg, state_next;
    mtps_pkg::in_item_t    item_reg;
    logic [ADDR_W-1:0]     init_cnt_reg, init_cnt_next;
    logic [ADDR_W-1:0]     addr_reg, addr_next;
    logic [15:0]           frame_reg, frame_next;
    logic                  live_reg, live_next;
    logic [WORD_W-1:0]     word_reg, word_next;
    logic [1:0]            k_reg, k_next;
    logic                  wrote_reg, wrote_next;
    logic                  result_valid_reg;
    mtps_pkg::out_item_t   result_reg, result_next;
    mtps_pkg::geom_t       geom_reg;
    logic [23:0]           colour_reg;

    logic                  accept;
    logic                  finish;
    logic                  on_screen;
    logic [31:0]           addr_full;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [WORD_W-1:0]     mem_wdata;
    logic [WORD_W-1:0]     clear_word;
    logic                  du_start;
    logic [12:0]           sx_u;
    logic [12:0]           sy_u;
    mtps_pkg::depth_res_t  du_res;
    logic [9:0]            sum_r;
    logic [9:0]            sum_g;
    logic [9:0]            sum_b;

    mtps_depth_unit u_depth (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (du_start),
        .geom    (geom_reg),
        .point_x (signed'({1'b0, sx_u})),
        .point_y (signed'({1'b0, sy_u})),
        .res     (du_res)
    );

    always_comb
    begin
        for (int k = 0; k < mtps_pkg::SAMPLES_PER_PIXEL; k++)
            clear_word[k*mtps_pkg::SAMPLE_W +: mtps_pkg::SAMPLE_W] = {24'd0, mtps_pkg::FAR_DEPTH};
        on_screen = (32'(item_reg.pixel_x) < 32'(SCREEN_WIDTH))
                 && (32'(item_reg.pixel_y) < 32'(SCREEN_HEIGHT));
        addr_full = (32'(SCREEN_HEIGHT - 1) - 32'(item_reg.pixel_y)) * 32'(SCREEN_WIDTH)
                  + 32'(item_reg.pixel_x);
        // Sample points sit at quarter offsets inside the pixel, in 12.4.
        sx_u = {1'b0, item_reg.pixel_x, 4'b0000} + {9'd0, k_reg[0], 3'b100};
        sy_u = {1'b0, item_reg.pixel_y, 4'b0000} + {9'd0, k_reg[1], 3'b100};
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        for (int k = 0; k < mtps_pkg::SAMPLES_PER_PIXEL; k++)
        begin
            sum_r = sum_r + 10'(word_reg[k*mtps_pkg::SAMPLE_W + 24 +: 8]);
            sum_g = sum_g + 10'(word_reg[k*mtps_pkg::SAMPLE_W + 32 +: 8]);
            sum_b = sum_b + 10'(word_reg[k*mtps_pkg::SAMPLE_W + 40 +: 8]);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mtps_pkg::ST_INIT:
                if (init_cnt_reg == ADDR_W'(DEPTH - 1)) state_next = mtps_pkg::ST_IDLE;
            mtps_pkg::ST_IDLE:
                if (item_valid) state_next = mtps_pkg::ST_DISPATCH;
            mtps_pkg::ST_DISPATCH:
                if (on_screen && item_reg.opcode == mtps_pkg::OP_SHADE)
                    state_next = mtps_pkg::ST_READ;
                else if (on_screen && item_reg.opcode == mtps_pkg::OP_CLEAR)
                    state_next = mtps_pkg::ST_WRITE;
                else
                    state_next = mtps_pkg::ST_FINISH;
            mtps_pkg::ST_READ:
                state_next = mtps_pkg::ST_LATCH;
            mtps_pkg::ST_LATCH:
                state_next = mtps_pkg::ST_SAMPLE;
            mtps_pkg::ST_SAMPLE:
                state_next = mtps_pkg::ST_WAIT;
            mtps_pkg::ST_WAIT:
                if (du_res.done)
                    state_next = (k_reg == 2'd3) ? mtps_pkg::ST_WRITE : mtps_pkg::ST_SAMPLE;
            mtps_pkg::ST_WRITE:
                state_next = mtps_pkg::ST_FINISH;
            mtps_pkg::ST_FINISH:
                if (finish) state_next = mtps_pkg::ST_IDLE;
            default:
                state_next = mtps_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        item_ready = (state_reg == mtps_pkg::ST_IDLE);
        accept     = item_ready && item_valid;
        finish     = (state_reg == mtps_pkg::ST_FINISH) && (!result_valid_reg || result_ready);
        du_start   = (state_reg == mtps_pkg::ST_SAMPLE);
        mem_we     = (state_reg == mtps_pkg::ST_INIT) || (state_reg == mtps_pkg::ST_WRITE);
        mem_waddr  = (state_reg == mtps_pkg::ST_INIT) ? init_cnt_reg : addr_reg;
        mem_wdata  = (state_reg == mtps_pkg::ST_INIT) ? clear_word : word_reg;
    end

    always_comb
    begin
        init_cnt_next = init_cnt_reg;
        addr_next     = addr_reg;
        frame_next    = frame_reg;
        live_next     = live_reg;
        word_next     = word_reg;
        k_next        = k_reg;
        wrote_next    = wrote_reg;
        result_next   = result_reg;

        unique case (state_reg)
            mtps_pkg::ST_INIT:
                init_cnt_next = init_cnt_reg + ADDR_W'(1);
            mtps_pkg::ST_DISPATCH:
            begin
                addr_next  = addr_full[ADDR_W-1:0];
                frame_next = addr_full[15:0];
                live_next  = on_screen && item_reg.opcode == mtps_pkg::OP_SHADE;
                word_next  = clear_word;
                wrote_next = 1'b0;
            end
            mtps_pkg::ST_LATCH:
            begin
                word_next = rdata_reg;
                k_next    = '0;
            end
            mtps_pkg::ST_WAIT:
            begin
                if (du_res.done)
                begin
                    // Strictly nearer only; a sample at far depth never replaces a stored entry.
                    if (du_res.ok && du_res.z < word_reg[k_reg*mtps_pkg::SAMPLE_W +: 24])
                    begin
                        word_next[k_reg*mtps_pkg::SAMPLE_W +: mtps_pkg::SAMPLE_W] =
                            {colour_reg, du_res.z};
                        wrote_next = 1'b1;
                    end
                    k_next = k_reg + 2'd1;
                end
            end
            mtps_pkg::ST_FINISH:
            begin
                if (live_reg)
                begin
                    result_next.written       = wrote_reg;
                    result_next.frame_address = frame_reg;
                    result_next.out_red       = sum_r[9:2];
                    result_next.out_green     = sum_g[9:2];
                    result_next.out_blue      = sum_b[9:2];
                end
                else
                begin
                    result_next = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= mtps_pkg::ST_INIT;
            init_cnt_reg     <= '0;
            result_valid_reg <= 1'b0;
            geom_reg         <= '0;
            colour_reg       <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            init_cnt_reg <= init_cnt_next;
            if (finish)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
            if (accept && item.opcode == mtps_pkg::OP_LOAD && item.vertex_slot != 2'd3)
            begin
                geom_reg.vx[item.vertex_slot] <= item.vertex_x;
                geom_reg.vy[item.vertex_slot] <= item.vertex_y;
                geom_reg.vz[item.vertex_slot] <= item.vertex_depth;
                if (item.vertex_slot == 2'd0)
                    colour_reg <= {item.blue, item.green, item.red};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item;
        addr_reg  <= addr_next;
        frame_reg <= frame_next;
        live_reg  <= live_next;
        word_reg  <= word_next;
        k_reg     <= k_next;
        wrote_reg <= wrote_next;
        if (finish)
            result_reg <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[addr_reg];
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// File: rtl/mtps_depth_unit.sv
// Coverage test and barycentric depth for one sample point, on one shared
// multiplier and a bit-serial divider. Depends on mtps_pkg.
module mtps_depth_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  mtps_pkg::geom_t       geom,
    input  logic signed [13:0]    point_x,
    input  logic signed [13:0]    point_y,
    output mtps_pkg::depth_res_t  res
);

    mtps_pkg::du_state_t state_reg, state_next;
    logic [4:0]               step_reg, step_next;
    logic signed [36:0]       edge_reg [3];
    logic signed [36:0]       edge_next [3];
    logic [35:0]              weight_reg [3];
    logic [35:0]              weight_next [3];
    logic [36:0]              den_reg, den_next;
    logic [60:0]              num_reg, num_next;
    logic [36:0]              rem_reg, rem_next;
    logic [23:0]              low_reg, low_next;
    logic [23:0]              quo_reg, quo_next;
    logic                     ok_reg, ok_next;

    logic signed [43:0]       prod_reg;
    logic                     pvalid_reg;
    logic [1:0]               pdst_reg;
    logic                     psub_reg;
    logic                     pnum_reg;
    logic                     phi_reg;

    logic                     issue;
    logic signed [18:0]       op_a;
    logic signed [24:0]       op_b;
    logic [1:0]               sel;
    logic [1:0]               va;
    logic [1:0]               vb;
    logic signed [16:0]       dx;
    logic signed [16:0]       dy;
    logic signed [16:0]       qx;
    logic signed [16:0]       qy;
    logic signed [36:0]       esum;
    logic                     all_pos;
    logic                     all_neg;
    logic [37:0]              trial;
    logic [37:0]              trial_diff;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mtps_pkg::DU_IDLE:
                if (start) state_next = mtps_pkg::DU_EDGE;
            mtps_pkg::DU_EDGE:
                if (step_reg == 5'd6) state_next = mtps_pkg::DU_CHECK;
            mtps_pkg::DU_CHECK:
                if (!(all_pos || all_neg) || esum == '0) state_next = mtps_pkg::DU_DONE;
                else state_next = mtps_pkg::DU_WEIGHT;
            mtps_pkg::DU_WEIGHT:
                if (step_reg == 5'd7) state_next = mtps_pkg::DU_DIVIDE;
            mtps_pkg::DU_DIVIDE:
                if (step_reg == 5'd23) state_next = mtps_pkg::DU_DONE;
            mtps_pkg::DU_DONE:
                state_next = mtps_pkg::DU_IDLE;
            default:
                state_next = mtps_pkg::DU_IDLE;
        endcase
    end

    // Operand selection for the shared multiplier. Edge i runs from vertex
    // i+1 to vertex i+2, so its weight pairs with the depth of vertex i.
    always_comb
    begin
        sel = step_reg[2:1];
        unique case (sel)
            2'd0:    begin va = 2'd1; vb = 2'd2; end
            2'd1:    begin va = 2'd2; vb = 2'd0; end
            default: begin va = 2'd0; vb = 2'd1; end
        endcase
        dx = 17'(signed'(geom.vx[vb])) - 17'(signed'(geom.vx[va]));
        dy = 17'(signed'(geom.vy[vb])) - 17'(signed'(geom.vy[va]));
        qx = 17'(point_x) - 17'(signed'(geom.vx[va]));
        qy = 17'(point_y) - 17'(signed'(geom.vy[va]));
        issue = 1'b0;
        op_a = '0;
        op_b = '0;
        if (state_reg == mtps_pkg::DU_EDGE && step_reg < 5'd6)
        begin
            issue = 1'b1;
            op_a  = step_reg[0] ? 19'(dy) : 19'(dx);
            op_b  = step_reg[0] ? 25'(qx) : 25'(qy);
        end
        else if (state_reg == mtps_pkg::DU_WEIGHT && step_reg < 5'd6)
        begin
            issue = 1'b1;
            op_a  = step_reg[0] ? signed'({1'b0, weight_reg[sel][35:18]})
                                : signed'({1'b0, weight_reg[sel][17:0]});
            op_b  = signed'({1'b0, geom.vz[sel]});
        end
    end

    always_comb
    begin
        esum    = edge_reg[0] + edge_reg[1] + edge_reg[2];
        all_pos = !edge_reg[0][36] && !edge_reg[1][36] && !edge_reg[2][36];
        all_neg = (edge_reg[0][36] || edge_reg[0] == '0)
               && (edge_reg[1][36] || edge_reg[1] == '0)
               && (edge_reg[2][36] || edge_reg[2] == '0);
        trial      = {rem_reg, low_reg[23]};
        trial_diff = trial - {1'b0, den_reg};

        step_next = step_reg + 5'd1;
        for (int i = 0; i < 3; i++)
        begin
            edge_next[i]   = edge_reg[i];
            weight_next[i] = weight_reg[i];
        end
        den_next = den_reg;
        num_next = num_reg;
        rem_next = rem_reg;
        low_next = low_reg;
        quo_next = quo_reg;
        ok_next  = ok_reg;

        if (pvalid_reg)
        begin
            if (pnum_reg)
                num_next = num_reg + (phi_reg ? (61'(prod_reg) << 18) : 61'(prod_reg));
            else
                edge_next[pdst_reg] = edge_reg[pdst_reg]
                    + (psub_reg ? -37'(prod_reg) : 37'(prod_reg));
        end

        unique case (state_reg)
            mtps_pkg::DU_IDLE:
            begin
                step_next = '0;
                for (int i = 0; i < 3; i++) edge_next[i] = '0;
                num_next = '0;
                ok_next  = 1'b0;
            end
            mtps_pkg::DU_CHECK:
            begin
                step_next = '0;
                ok_next   = (all_pos || all_neg) && esum != '0;
                for (int i = 0; i < 3; i++)
                    weight_next[i] = esum[36] ? 36'(-edge_reg[i]) : 36'(edge_reg[i]);
                den_next = esum[36] ? 37'(-esum) : 37'(esum);
            end
            mtps_pkg::DU_WEIGHT:
            begin
                if (step_reg == 5'd7)
                begin
                    step_next = '0;
                    rem_next  = num_reg[60:24];
                    low_next  = num_reg[23:0];
                end
            end
            mtps_pkg::DU_DIVIDE:
            begin
                low_next = {low_reg[22:0], 1'b0};
                if (!trial_diff[37])
                begin
                    rem_next = trial_diff[36:0];
                    quo_next = {quo_reg[22:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[36:0];
                    quo_next = {quo_reg[22:0], 1'b0};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        res.done = (state_reg == mtps_pkg::DU_DONE);
        res.ok   = ok_reg;
        res.z    = quo_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= mtps_pkg::DU_IDLE;
            step_reg   <= '0;
            pvalid_reg <= 1'b0;
            ok_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            pvalid_reg <= issue;
            ok_reg     <= ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
        pdst_reg <= sel;
        psub_reg <= step_reg[0];
        pnum_reg <= (state_reg == mtps_pkg::DU_WEIGHT);
        phi_reg  <= step_reg[0];
        for (int i = 0; i < 3; i++)
        begin
            edge_reg[i]   <= edge_next[i];
            weight_reg[i] <= weight_next[i];
        end
        den_reg <= den_next;
        num_reg <= num_next;
        rem_reg <= rem_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
    end

endmodule

// File: bench/msaa_shader_checker.sv
// Checker for the supersampled triangle pixel shader: watches both channels,
// predicts each result from its own model of the sample store and compares.
// Depends on mtps_pkg.
`timescale 1ns / 1ps

module msaa_shader_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                item_ready,
    input  mtps_pkg::in_item_t  item,
    input  logic                result_valid,
    input  logic                result_ready,
    input  mtps_pkg::out_item_t result,
    output int                  fail_count,
    output int                  pending,
    output int                  shade_count,
    output int                  written_count
);

    logic [23:0] store_depth [bit [17:0]];
    logic [23:0] store_colour [bit [17:0]];
    logic signed [15:0] tri_x [3];
    logic signed [15:0] tri_y [3];
    logic [23:0] tri_z [3];
    logic [23:0] tri_rgb;
    mtps_pkg::out_item_t pixel_results [$];

    function automatic logic signed [47:0] edge_value(int a, int b,
                                                    longint sx, longint sy);
        longint ax, ay, bx, by;
        ax = tri_x[a]; ay = tri_y[a]; bx = tri_x[b]; by = tri_y[b];
        return (bx - ax) * (sy - ay) - (by - ay) * (sx - ax);
    endfunction

    function automatic logic [23:0] depth_at(bit [17:0] idx);
        return store_depth.exists(idx) ? store_depth[idx] : mtps_pkg::FAR_DEPTH;
    endfunction

    function automatic logic [23:0] colour_at(bit [17:0] idx);
        return store_colour.exists(idx) ? store_colour[idx] : 24'd0;
    endfunction

    function automatic bit shade_one(bit [17:0] idx, longint sx, longint sy);
        longint wg, wa, wb, wsum;
        logic [127:0] num;
        logic [127:0] zq;
        wg = edge_value(0, 1, sx, sy);
        wa = edge_value(1, 2, sx, sy);
        wb = edge_value(2, 0, sx, sy);
        if (!((wa >= 0 && wb >= 0 && wg >= 0) || (wa <= 0 && wb <= 0 && wg <= 0)))
            return 0;
        wsum = wa + wb + wg;
        if (wsum == 0)
            return 0;
        if (wsum < 0)
        begin
            wa = -wa; wb = -wb; wg = -wg; wsum = -wsum;
        end
        num = 128'(wa) * tri_z[0] + 128'(wb) * tri_z[1] + 128'(wg) * tri_z[2];
        zq = num / 128'(wsum);
        if (zq >= depth_at(idx))
            return 0;
        store_depth[idx] = zq[23:0];
        store_colour[idx] = tri_rgb;
        return 1;
    endfunction

    function automatic mtps_pkg::out_item_t shade_step(mtps_pkg::in_item_t it);
        mtps_pkg::out_item_t r;
        int unsigned addr, sr, sg, sb;
        bit [17:0] base;
        bit hit;
        logic [23:0] c;
        r = '0;
        sr = 0; sg = 0; sb = 0; hit = 0;
        case (it.opcode)
            mtps_pkg::OP_LOAD:
            begin
                if (it.vertex_slot != 2'd3)
                begin
                    tri_x[it.vertex_slot] = it.vertex_x;
                    tri_y[it.vertex_slot] = it.vertex_y;
                    tri_z[it.vertex_slot] = it.vertex_depth;
                    if (it.vertex_slot == 2'd0)
                        tri_rgb = {it.blue, it.green, it.red};
                end
            end
            mtps_pkg::OP_CLEAR, mtps_pkg::OP_SHADE:
            begin
                addr = (mtps_pkg::SCREEN_HEIGHT - 1 - it.pixel_y) * mtps_pkg::SCREEN_WIDTH
                     + it.pixel_x;
                base = 18'(addr * mtps_pkg::SAMPLES_PER_PIXEL);
                for (int k = 0; k < mtps_pkg::SAMPLES_PER_PIXEL; k++)
                begin
                    if (it.opcode == mtps_pkg::OP_CLEAR)
                    begin
                        store_depth[base + k] = mtps_pkg::FAR_DEPTH;
                        store_colour[base + k] = 24'd0;
                    end
                    else if (shade_one(base + k, longint'(it.pixel_x) * 16 + 4 + 8 * (k % 2),
                                       longint'(it.pixel_y) * 16 + 4 + 8 * (k / 2)))
                        hit = 1;
                end
                if (it.opcode == mtps_pkg::OP_SHADE)
                begin
                    for (int k = 0; k < mtps_pkg::SAMPLES_PER_PIXEL; k++)
                    begin
                        c = colour_at(base + k);
                        sr += c[7:0]; sg += c[15:8]; sb += c[23:16];
                    end
                    r.written = hit;
                    r.frame_address = addr[15:0];
                    r.out_red = 8'(sr / 4);
                    r.out_green = 8'(sg / 4);
                    r.out_blue = 8'(sb / 4);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        mtps_pkg::out_item_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
            pending <= 0;
            shade_count <= 0;
            written_count <= 0;
            tri_rgb = '0;
            for (int i = 0; i < 3; i++)
            begin
                tri_x[i] = '0; tri_y[i] = '0; tri_z[i] = '0;
            end
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                pixel_results.push_back(shade_step(item));
                if (item.opcode == mtps_pkg::OP_SHADE)
                    shade_count <= shade_count + 1;
            end
            if (result_valid && result_ready)
            begin
                if (pixel_results.size() == 0)
                begin
                    $display("%0t: unexpected result beat %p", $time, result);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = pixel_results.pop_front();
                    if (want.written)
                        written_count <= written_count + 1;
                    if (want !== result)
                    begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, result);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= pixel_results.size();
        end
    end

endmodule

// File: bench/tb_msaa_triangle_pixel_shader_core.sv
// Top of the shader testbench: clock, reset, stimulus and verdict.
// Depends on mtps_pkg, msaa_triangle_pixel_shader_core and msaa_shader_checker.
`timescale 1ns / 1ps

module tb_msaa_triangle_pixel_shader_core;

    logic clk = 0;
    logic rst_n = 0;
    logic item_valid = 0;
    logic item_ready;
    mtps_pkg::in_item_t item = '0;
    logic result_valid;
    logic result_ready = 0;
    mtps_pkg::out_item_t result;
    int fail_count, pending, shade_count, written_count;
    int send_idle = 0;
    int recv_stall = 0;
    int item_total = 0;

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    msaa_triangle_pixel_shader_core DUT (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready), .item(item),
        .result_valid(result_valid), .result_ready(result_ready), .result(result)
    );

    msaa_shader_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready), .item(item),
        .result_valid(result_valid), .result_ready(result_ready), .result(result),
        .fail_count(fail_count), .pending(pending),
        .shade_count(shade_count), .written_count(written_count)
    );

    always @(posedge clk)
        result_ready <= ($urandom_range(99) >= recv_stall);

    // Presents one beat and holds it until accepted. Valid drops only while
    // the sender idles, so back-to-back beats keep it high.
    task automatic send(mtps_pkg::in_item_t it);
        while ($urandom_range(99) < send_idle)
        begin
            item_valid <= 0;
            @(posedge clk);
        end
        item <= it;
        item_valid <= 1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        item_total++;
    endtask

    function automatic mtps_pkg::in_item_t random_beat();
        mtps_pkg::in_item_t it;
        logic [127:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom};
        it = bits[$bits(mtps_pkg::in_item_t)-1:0];
        return it;
    endfunction

    task automatic load_vertex(int slot, int x, int y, int z, bit [23:0] rgb);
        mtps_pkg::in_item_t it;
        it = random_beat();
        it.opcode = mtps_pkg::OP_LOAD;
        it.vertex_slot = 2'(slot);
        it.vertex_x = 16'(x);
        it.vertex_y = 16'(y);
        it.vertex_depth = 24'(z);
        {it.blue, it.green, it.red} = rgb;
        send(it);
    endtask

    task automatic pixel_op(mtps_pkg::op_t op, int px, int py);
        mtps_pkg::in_item_t it;
        it = random_beat();
        it.opcode = op;
        it.pixel_x = 8'(px);
        it.pixel_y = 8'(py);
        send(it);
    endtask

    // A triangle near a random spot so that its pixels get covered.
    task automatic random_triangle(int cx, int cy);
        for (int v = 0; v < 3; v++)
            load_vertex(v, cx + $urandom_range(1600) - 800, cy + $urandom_range(1600) - 800,
                        ($urandom_range(3) == 0) ? $urandom : $urandom_range(4000),
                        24'($urandom));
    endtask

    task automatic random_phase(int count);
        int cx, cy;
        mtps_pkg::in_item_t it;
        while (count > 0)
        begin
            if ($urandom_range(9) < 8)
            begin
                cx = $urandom_range(4095);
                cy = $urandom_range(4095);
                random_triangle(cx, cy);
                count -= 3;
                for (int n = $urandom_range(6, 1); n > 0; n--)
                begin
                    pixel_op(($urandom_range(7) == 0) ? mtps_pkg::OP_CLEAR : mtps_pkg::OP_SHADE,
                             (cx >> 4) + $urandom_range(8) - 4,
                             (cy >> 4) + $urandom_range(8) - 4);
                    count--;
                end
            end
            else
            begin
                it = random_beat();
                send(it);
                count--;
            end
        end
    endtask

    task automatic drain();
        item_valid <= 0;
        while (pending != 0 || item_valid)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1;
        // Directed: extremes, both windings, degenerate, unused codes, far depth.
        load_vertex(0, 0, 0, 100, 24'hFF_FFFF);
        load_vertex(1, 160, 0, 200, 24'h0);
        load_vertex(2, 0, 160, 300, 24'h0);
        pixel_op(mtps_pkg::OP_SHADE, 0, 0);
        pixel_op(mtps_pkg::OP_SHADE, 0, 0);
        pixel_op(mtps_pkg::OP_SHADE, 9, 9);
        load_vertex(1, 0, 160, 50, 0);
        load_vertex(2, 160, 0, 60, 0);
        pixel_op(mtps_pkg::OP_SHADE, 0, 0);
        pixel_op(mtps_pkg::OP_CLEAR, 0, 0);
        pixel_op(mtps_pkg::OP_SHADE, 0, 0);
        load_vertex(3, 5, 5, 5, 0);
        pixel_op(mtps_pkg::OP_NONE, 1, 1);
        load_vertex(0, -32768, -32768, 24'hFF_FFFF, 24'h123456);
        load_vertex(1, 32767, -32768, 24'hFF_FFFF, 0);
        load_vertex(2, -32768, 32767, 24'hFF_FFFF, 0);
        pixel_op(mtps_pkg::OP_SHADE, 255, 255);
        pixel_op(mtps_pkg::OP_SHADE, 255, 0);
        pixel_op(mtps_pkg::OP_CLEAR, 255, 255);
        load_vertex(0, 10, 10, 0, 24'hABCDEF);
        load_vertex(1, 20, 20, 0, 0);
        load_vertex(2, 30, 30, 0, 0);
        pixel_op(mtps_pkg::OP_SHADE, 1, 1);
        drain();
        random_phase(700);
        send_idle = 84;
        random_phase(300);
        drain();
        send_idle = 0;
        recv_stall = 84;
        random_phase(300);
        send_idle = 10;
        recv_stall = 10;
        random_phase(400);
        drain();
        $display("Sent %0d beats, %0d shades, %0d wrote samples, under four idle patterns.",
                 item_total, shade_count, written_count);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: filelist.f
rtl/mtps_pkg.sv
rtl/mtps_depth_unit.sv
rtl/msaa_triangle_pixel_shader_core.sv
bench/msaa_shader_checker.sv
bench/tb_msaa_triangle_pixel_shader_core.sv
